// File: sv/tems_pkg.sv
// Shared types, constants and the search-order function of the TLB lookup block.
package tems_pkg;

  localparam int NUM_ENTRIES = 48;
  localparam int ACT_W = 2;
  localparam int IDX_W = 6;
  localparam int VPN2_W = 19;
  localparam int ADDR_W = 32;
  localparam int PAGE_SHIFT = 13;
  localparam int SPR_SHIFT = 14;
  localparam int GROUP_W = 8;
  localparam int NUM_GROUPS = NUM_ENTRIES / GROUP_W;
  localparam int GROUP_POS_W = 3;

  localparam int DEF_CMD_DEPTH = 2;
  localparam int DEF_RES_DEPTH = 4;

  localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_READ = 2'd1;
  localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd2;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_READ,
    OP_LOOKUP,
    OP_NONE
  } cmd_op_e;

  // word carries the mask of a write or the address of a lookup
  typedef struct packed {
    cmd_op_e             op;
    logic [IDX_W-1:0]    index;
    logic                spr;
    logic [VPN2_W-1:0]   vpn2;
    logic [ADDR_W-1:0]   word;
  } cmd_t;

  typedef struct packed {
    logic                hit;
    logic [IDX_W-1:0]    match_index;
    logic                spr;
    logic [VPN2_W-1:0]   vpn2;
    logic [ADDR_W-1:0]   mask;
  } res_t;

  // Slot checked at position k of the priority order: 0, 13..30, 1..12, 31..47.
  function automatic logic [IDX_W-1:0] search_slot(input logic [IDX_W-1:0] k);
    logic [IDX_W-1:0] slot;
    if (k == '0) begin
      slot = '0;
    end else if (k <= IDX_W'(18)) begin
      slot = k + IDX_W'(12);
    end else if (k <= IDX_W'(30)) begin
      slot = k - IDX_W'(18);
    end else begin
      slot = k;
    end
    return slot;
  endfunction

endpackage

// File: sv/tlb_entry_match_search_unit.sv
// Top level of the 48-entry fully associative TLB: front queue, table back end, result queue.
//
//   channel   handshake         payload
//   input     push / full       action_i entry_index_i entry_spr_i entry_vpn2_i
//                               entry_mask_i virtual_address_i
//   result    empty / pop       hit_o match_index_o read_spr_o read_vpn2_o read_mask_o
//
// Every beat (write, read, lookup, no-op) gives one result beat, in order.
// One beat per cycle sustained while the result queue has room; an accepted beat passes
// from the command queue into the match/read register stage, and from there into the
// result queue.
// Reset clears all entries to zero; writes update the table at the match stage.
// The back end holds commands while the result queue lacks room; full rises when the
// command queue fills, so either side stalls without losing a beat.
module tlb_entry_match_search_unit #(
  parameter int CMD_DEPTH = tems_pkg::DEF_CMD_DEPTH,
  parameter int RES_DEPTH = tems_pkg::DEF_RES_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [tems_pkg::ACT_W-1:0]    action_i,
  input  logic [tems_pkg::IDX_W-1:0]    entry_index_i,
  input  logic                          entry_spr_i,
  input  logic [tems_pkg::VPN2_W-1:0]   entry_vpn2_i,
  input  logic [tems_pkg::ADDR_W-1:0]   entry_mask_i,
  input  logic [tems_pkg::ADDR_W-1:0]   virtual_address_i,
  output logic                          empty,
  input  logic                          pop,
  output logic                          hit_o,
  output logic [tems_pkg::IDX_W-1:0]    match_index_o,
  output logic                          read_spr_o,
  output logic [tems_pkg::VPN2_W-1:0]   read_vpn2_o,
  output logic [tems_pkg::ADDR_W-1:0]   read_mask_o
);

  localparam int RES_W = $bits(tems_pkg::res_t);
  localparam int CNT_W = $clog2(RES_DEPTH+1);

  tems_pkg::cmd_t   cmd;
  logic             cmd_empty;
  logic             cmd_pop;
  logic [CNT_W-1:0] res_count;
  logic             res_push;
  tems_pkg::res_t   res_in;
  logic [RES_W-1:0] res_bits;
  tems_pkg::res_t   res_out;

  tems_front #(
    .CMD_DEPTH(CMD_DEPTH)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .full_o           (full),
    .action_i         (action_i),
    .entry_index_i    (entry_index_i),
    .entry_spr_i      (entry_spr_i),
    .entry_vpn2_i     (entry_vpn2_i),
    .entry_mask_i     (entry_mask_i),
    .virtual_address_i(virtual_address_i),
    .cmd_o            (cmd),
    .cmd_empty_o      (cmd_empty),
    .cmd_pop_i        (cmd_pop)
  );

  tems_back #(
    .RES_DEPTH(RES_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cmd_empty_i(cmd_empty),
    .cmd_pop_o  (cmd_pop),
    .res_count_i(res_count),
    .res_push_o (res_push),
    .res_o      (res_in)
  );

  tems_fifo #(
    .WIDTH(RES_W),
    .DEPTH(RES_DEPTH)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .full_o (),
    .pop_i  (pop),
    .data_o (res_bits),
    .empty_o(empty),
    .count_o(res_count)
  );

  assign res_out       = tems_pkg::res_t'(res_bits);
  assign hit_o         = res_out.hit;
  assign match_index_o = res_out.match_index;
  assign read_spr_o    = res_out.spr;
  assign read_vpn2_o   = res_out.vpn2;
  assign read_mask_o   = res_out.mask;

endmodule

// File: sv/tems_fifo.sv
// Small synchronous queue with push/full and pop/empty sides and an occupancy count.
module tems_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           data_i,
  output logic                       full_o,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           data_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH+1);

  logic [WIDTH-1:0] store_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign data_o  = store_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: sv/tems_front.sv
// Front end: takes input beats, classifies the action and queues commands for the table.
module tems_front #(
  parameter int CMD_DEPTH = tems_pkg::DEF_CMD_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  output logic                          full_o,
  input  logic [tems_pkg::ACT_W-1:0]    action_i,
  input  logic [tems_pkg::IDX_W-1:0]    entry_index_i,
  input  logic                          entry_spr_i,
  input  logic [tems_pkg::VPN2_W-1:0]   entry_vpn2_i,
  input  logic [tems_pkg::ADDR_W-1:0]   entry_mask_i,
  input  logic [tems_pkg::ADDR_W-1:0]   virtual_address_i,
  output tems_pkg::cmd_t                cmd_o,
  output logic                          cmd_empty_o,
  input  logic                          cmd_pop_i
);

  localparam int CMD_W = $bits(tems_pkg::cmd_t);

  tems_pkg::cmd_t   cmd_in;
  logic             idx_ok;
  logic [CMD_W-1:0] cmd_bits;

  assign idx_ok = (entry_index_i < tems_pkg::IDX_W'(tems_pkg::NUM_ENTRIES));

  // Out-of-range slots and the unused code turn into a no-op that answers zero.
  always_comb begin
    cmd_in.index = entry_index_i;
    cmd_in.spr   = entry_spr_i;
    cmd_in.vpn2  = entry_vpn2_i;
    cmd_in.word  = entry_mask_i;
    unique case (action_i)
      tems_pkg::ACT_WRITE: begin
        cmd_in.op = idx_ok ? tems_pkg::OP_WRITE : tems_pkg::OP_NONE;
      end
      tems_pkg::ACT_READ: begin
        cmd_in.op = idx_ok ? tems_pkg::OP_READ : tems_pkg::OP_NONE;
      end
      tems_pkg::ACT_LOOKUP: begin
        cmd_in.op   = tems_pkg::OP_LOOKUP;
        cmd_in.word = virtual_address_i;
      end
      default: begin
        cmd_in.op = tems_pkg::OP_NONE;
      end
    endcase
  end

  tems_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .data_i (cmd_in),
    .full_o (full_o),
    .pop_i  (cmd_pop_i),
    .data_o (cmd_bits),
    .empty_o(cmd_empty_o),
    .count_o()
  );

  assign cmd_o = tems_pkg::cmd_t'(cmd_bits);

endmodule

// File: sv/tems_back.sv
// Back end: entry table with parallel match, read port and priority encode into results.
module tems_back #(
  parameter int RES_DEPTH = tems_pkg::DEF_RES_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tems_pkg::cmd_t                 cmd_i,
  input  logic                           cmd_empty_i,
  output logic                           cmd_pop_o,
  input  logic [$clog2(RES_DEPTH+1)-1:0] res_count_i,
  output logic                           res_push_o,
  output tems_pkg::res_t                 res_o
);

  localparam int N = tems_pkg::NUM_ENTRIES;
  localparam int IDX_W = tems_pkg::IDX_W;
  localparam int VPN2_W = tems_pkg::VPN2_W;
  localparam int ADDR_W = tems_pkg::ADDR_W;
  localparam int CNT_W = $clog2(RES_DEPTH+1);
  localparam int ENT_W = 1 + VPN2_W + ADDR_W;
  localparam int PG = tems_pkg::PAGE_SHIFT;
  localparam int SP = tems_pkg::SPR_SHIFT;
  localparam int GW = tems_pkg::GROUP_W;
  localparam int NG = tems_pkg::NUM_GROUPS;
  localparam int GP_W = tems_pkg::GROUP_POS_W;

  // match copy: one register set per entry, compared in parallel
  logic              cam_spr_q  [N];
  logic [VPN2_W-1:0] cam_vpn2_q [N];
  logic [ADDR_W-1:0] cam_mask_q [N];

  // read copy: memory with per-entry valid bits standing for the zero reset
  logic [ENT_W-1:0]  ram_q [N];
  logic [N-1:0]      ram_vld_q;

  logic              s1_valid_q;
  tems_pkg::cmd_op_e s1_op_q;
  logic [N-1:0]      s1_match_q;
  logic [ENT_W-1:0]  s1_rd_q;
  logic              s1_rd_vld_q;

  logic              issue;
  logic [CNT_W:0]    in_flight;
  logic [N-1:0]      match_raw;
  logic [N-1:0]      match_ord;
  logic [ADDR_W-1:0] va;
  logic [ADDR_W-1:0] masked;

  // issue only with room in the result queue for everything already in flight
  assign in_flight = {1'b0, res_count_i} + {{CNT_W{1'b0}}, s1_valid_q};
  assign issue     = !cmd_empty_i && (in_flight < (CNT_W+1)'(RES_DEPTH));
  assign cmd_pop_o = issue;
  assign va        = cmd_i.word;

  always_comb begin
    masked = '0;
    for (int e = 0; e < N; e++) begin
      masked = va & cam_mask_q[e];
      match_raw[e] =
        (cam_spr_q[e] && (va[ADDR_W-1:SP] == cam_vpn2_q[e][VPN2_W-1:1])) ||
        (masked[ADDR_W-1:PG] == cam_vpn2_q[e]);
    end
    for (int k = 0; k < N; k++) begin
      match_ord[k] = match_raw[tems_pkg::search_slot(IDX_W'(k))];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      ram_vld_q  <= '0;
      for (int e = 0; e < N; e++) begin
        cam_spr_q[e]  <= 1'b0;
        cam_vpn2_q[e] <= '0;
        cam_mask_q[e] <= '0;
      end
    end else begin
      s1_valid_q <= issue;
      if (issue && cmd_i.op == tems_pkg::OP_WRITE) begin
        cam_spr_q[cmd_i.index]  <= cmd_i.spr;
        cam_vpn2_q[cmd_i.index] <= cmd_i.vpn2;
        cam_mask_q[cmd_i.index] <= cmd_i.word;
        ram_vld_q[cmd_i.index]  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_op_q     <= cmd_i.op;
      s1_match_q  <= match_ord;
      s1_rd_q     <= ram_q[cmd_i.index];
      s1_rd_vld_q <= ram_vld_q[cmd_i.index];
      if (cmd_i.op == tems_pkg::OP_WRITE) begin
        ram_q[cmd_i.index] <= {cmd_i.spr, cmd_i.vpn2, cmd_i.word};
      end
    end
  end

  // priority encode in two levels: first hit inside each group, then first group
  logic [NG-1:0]   grp_any;
  logic [GP_W-1:0] grp_pos [NG];
  logic            any_hit;
  logic [IDX_W-1:0] first_k;

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_any[g] = |s1_match_q[g*GW +: GW];
      grp_pos[g] = '0;
      for (int i = GW-1; i >= 0; i--) begin
        if (s1_match_q[g*GW + i]) begin
          grp_pos[g] = GP_W'(i);
        end
      end
    end
    any_hit = |grp_any;
    first_k = '0;
    for (int g = NG-1; g >= 0; g--) begin
      if (grp_any[g]) begin
        first_k = IDX_W'(g*GW) + IDX_W'(grp_pos[g]);
      end
    end
  end

  always_comb begin
    res_o = '0;
    unique case (s1_op_q)
      tems_pkg::OP_LOOKUP: begin
        res_o.hit = any_hit;
        res_o.match_index = any_hit ? tems_pkg::search_slot(first_k) : '0;
      end
      tems_pkg::OP_READ: begin
        if (s1_rd_vld_q) begin
          {res_o.spr, res_o.vpn2, res_o.mask} = s1_rd_q;
        end
      end
      default: begin
        res_o = '0;
      end
    endcase
  end

  assign res_push_o = s1_valid_q;

endmodule

// File: tb/sv/tlb_entry_match_search_unit_tb.sv
// Self-checking testbench for the 48-entry TLB table: write, read and priority lookup beats.
module tlb_entry_match_search_unit_tb;
  import tems_pkg::*;

  localparam logic [ACT_W-1:0] ACT_NOOP = 2'd3;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [IDX_W-1:0]  index;
    logic              spr;
    logic [VPN2_W-1:0] vpn2;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] vaddr;
  } tlb_cmd_t;

  logic              clk = 1'b0;
  logic              rst_ni = 1'b0;
  logic              push = 1'b0;
  logic              pop = 1'b0;
  logic [ACT_W-1:0]  action_i = '0;
  logic [IDX_W-1:0]  entry_index_i = '0;
  logic              entry_spr_i = 1'b0;
  logic [VPN2_W-1:0] entry_vpn2_i = '0;
  logic [ADDR_W-1:0] entry_mask_i = '0;
  logic [ADDR_W-1:0] virtual_address_i = '0;
  logic              full;
  logic              empty;
  logic              hit_o;
  logic [IDX_W-1:0]  match_index_o;
  logic              read_spr_o;
  logic [VPN2_W-1:0] read_vpn2_o;
  logic [ADDR_W-1:0] read_mask_o;

  tlb_entry_match_search_unit dut (
    .clk_i             (clk),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .action_i          (action_i),
    .entry_index_i     (entry_index_i),
    .entry_spr_i       (entry_spr_i),
    .entry_vpn2_i      (entry_vpn2_i),
    .entry_mask_i      (entry_mask_i),
    .virtual_address_i (virtual_address_i),
    .empty             (empty),
    .pop               (pop),
    .hit_o             (hit_o),
    .match_index_o     (match_index_o),
    .read_spr_o        (read_spr_o),
    .read_vpn2_o       (read_vpn2_o),
    .read_mask_o       (read_mask_o)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow table updated as beats are accepted
  logic              tbl_spr  [NUM_ENTRIES] = '{default: 1'b0};
  logic [VPN2_W-1:0] tbl_vpn2 [NUM_ENTRIES] = '{default: '0};
  logic [ADDR_W-1:0] tbl_mask [NUM_ENTRIES] = '{default: '0};
  int                probe_order[$];

  // generator-side copy of the written content, used to aim lookups and to copy slots into writes
  logic              aim_spr  [NUM_ENTRIES] = '{default: 1'b0};
  logic [VPN2_W-1:0] aim_vpn2 [NUM_ENTRIES] = '{default: '0};
  logic [ADDR_W-1:0] aim_mask [NUM_ENTRIES] = '{default: '0};

  tlb_cmd_t pending_cmds[$];
  res_t     tlb_results_due[$];
  tlb_cmd_t next_cmd;
  logic     beat_taken = 1'b0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;

  int mismatch_count = 0;
  int results_checked = 0;
  int n_write = 0, n_read = 0, n_lookup = 0, n_hit = 0, n_noop = 0, n_out_of_range = 0;

  initial begin
    probe_order.push_back(0);
    for (int s = 13; s <= 30; s++) probe_order.push_back(s);
    for (int s = 1; s <= 12; s++) probe_order.push_back(s);
    for (int s = 31; s < NUM_ENTRIES; s++) probe_order.push_back(s);
  end

  function automatic bit entry_covers(int s, logic [ADDR_W-1:0] va);
    if (tbl_spr[s] && (va[ADDR_W-1:SPR_SHIFT] == tbl_vpn2[s][VPN2_W-1:1])) return 1'b1;
    return ((va & tbl_mask[s]) >> PAGE_SHIFT) == ADDR_W'(tbl_vpn2[s]);
  endfunction

  function automatic res_t tlb_apply(tlb_cmd_t c);
    res_t r;
    r = '0;
    case (c.action)
      ACT_WRITE: begin
        n_write++;
        if (c.index < NUM_ENTRIES) begin
          tbl_spr[c.index]  = c.spr;
          tbl_vpn2[c.index] = c.vpn2;
          tbl_mask[c.index] = c.mask;
        end else begin
          n_out_of_range++;
        end
      end
      ACT_READ: begin
        n_read++;
        if (c.index < NUM_ENTRIES) begin
          r.spr  = tbl_spr[c.index];
          r.vpn2 = tbl_vpn2[c.index];
          r.mask = tbl_mask[c.index];
        end else begin
          n_out_of_range++;
        end
      end
      ACT_LOOKUP: begin
        n_lookup++;
        foreach (probe_order[k]) begin
          if (!r.hit && entry_covers(probe_order[k], c.vaddr)) begin
            r.hit = 1'b1;
            r.match_index = IDX_W'(probe_order[k]);
          end
        end
        if (r.hit) n_hit++;
      end
      default: n_noop++;
    endcase
    return r;
  endfunction

  task automatic check_field(string name, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // accept input beats into the predictor, then check result beats
  always @(posedge clk) begin
    res_t want;
    tlb_cmd_t seen;
    if (rst_ni) begin
      beat_taken <= push && !full;
      if (push && !full) begin
        seen = '{action_i, entry_index_i, entry_spr_i, entry_vpn2_i, entry_mask_i,
                 virtual_address_i};
        tlb_results_due.push_back(tlb_apply(seen));
      end
      if (pop && !empty) begin
        if (tlb_results_due.size() == 0) begin
          $error("result beat with no expectation waiting");
          mismatch_count++;
        end else begin
          want = tlb_results_due.pop_front();
          results_checked++;
          check_field("hit", ADDR_W'(want.hit), ADDR_W'(hit_o));
          check_field("match_index", ADDR_W'(want.match_index), ADDR_W'(match_index_o));
          check_field("read_spr", ADDR_W'(want.spr), ADDR_W'(read_spr_o));
          check_field("read_vpn2", ADDR_W'(want.vpn2), ADDR_W'(read_vpn2_o));
          check_field("read_mask", want.mask, read_mask_o);
        end
      end
    end
  end

  // drive at the falling edge; hold a beat until it is taken
  always @(negedge clk) begin
    if (rst_ni) begin
      if (!push || beat_taken) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          next_cmd          = pending_cmds.pop_front();
          push              <= 1'b1;
          action_i          <= next_cmd.action;
          entry_index_i     <= next_cmd.index;
          entry_spr_i       <= next_cmd.spr;
          entry_vpn2_i      <= next_cmd.vpn2;
          entry_mask_i      <= next_cmd.mask;
          virtual_address_i <= next_cmd.vaddr;
        end else begin
          push <= 1'b0;
        end
      end
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic tlb_cmd_t make_cmd(logic [ACT_W-1:0] act, logic [IDX_W-1:0] idx,
                                        logic spr, logic [VPN2_W-1:0] vpn2,
                                        logic [ADDR_W-1:0] mask, logic [ADDR_W-1:0] va);
    tlb_cmd_t c;
    c = '{act, idx, spr, vpn2, mask, va};
    return c;
  endfunction

  task automatic queue_cmd(tlb_cmd_t c);
    pending_cmds.push_back(c);
    if (c.action == ACT_WRITE && c.index < NUM_ENTRIES) begin
      aim_spr[c.index]  = c.spr;
      aim_vpn2[c.index] = c.vpn2;
      aim_mask[c.index] = c.mask;
    end
  endtask

  function automatic tlb_cmd_t random_noise();
    tlb_cmd_t c;
    c.action = ACT_W'($urandom);
    c.index  = IDX_W'($urandom);
    c.spr    = 1'($urandom);
    c.vpn2   = VPN2_W'($urandom);
    c.mask   = $urandom;
    c.vaddr  = $urandom;
    return c;
  endfunction

  function automatic tlb_cmd_t random_write(logic [IDX_W-1:0] idx);
    tlb_cmd_t c;
    int pick, src;
    c = random_noise();
    c.action = ACT_WRITE;
    c.index = idx;
    pick = $urandom_range(99);
    if (pick < 45) begin
      // page-style mask, page number confined to the masked bits so lookups can hit
      c.mask = 32'hffff_ffff << $urandom_range(13, 31);
      c.vpn2 = VPN2_W'($urandom) & VPN2_W'(c.mask >> PAGE_SHIFT);
    end else if (pick < 65) begin
      // duplicate another slot to exercise priority among several matches
      src = $urandom_range(NUM_ENTRIES - 1);
      c.spr  = aim_spr[src];
      c.vpn2 = aim_vpn2[src];
      c.mask = aim_mask[src];
    end
    return c;
  endfunction

  function automatic tlb_cmd_t random_item();
    tlb_cmd_t c;
    int pick, aim;
    logic [IDX_W-1:0] idx;
    pick = $urandom_range(99);
    idx = ($urandom_range(9) == 0) ? IDX_W'($urandom_range(63))
                                   : IDX_W'($urandom_range(NUM_ENTRIES - 1));
    c = random_noise();
    if (pick < 25) begin
      c = random_write(idx);
    end else if (pick < 40) begin
      c.action = ACT_READ;
      c.index = idx;
    end else if (pick < 95) begin
      c.action = ACT_LOOKUP;
      pick = $urandom_range(99);
      if (pick < 60) begin
        aim = $urandom_range(NUM_ENTRIES - 1);
        if (aim_spr[aim] && $urandom_range(1))
          c.vaddr[ADDR_W-1:SPR_SHIFT] = aim_vpn2[aim][VPN2_W-1:1];
        else
          c.vaddr = (c.vaddr & ~aim_mask[aim]) | ({aim_vpn2[aim], 13'b0} & aim_mask[aim]);
      end else if (pick < 90) begin
        c.vaddr = $urandom;
      end else begin
        c.vaddr = $urandom_range(1) ? 32'hffff_ffff : 32'h0;
      end
    end else begin
      c.action = ACT_NOOP;
    end
    return c;
  endfunction

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || push || tlb_results_due.size() > 0) @(posedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // directed: reset contents, extremes, out-of-range slots, unused action, priority
    queue_cmd(make_cmd(ACT_LOOKUP, 6'd0, 1'b0, '0, '0, 32'h0));
    queue_cmd(make_cmd(ACT_LOOKUP, 6'd0, 1'b0, '0, '0, 32'hffff_ffff));
    queue_cmd(make_cmd(ACT_READ, 6'd0, 1'b1, '1, '1, '1));
    queue_cmd(make_cmd(ACT_READ, 6'd47, 1'b0, '0, '0, '0));
    queue_cmd(make_cmd(ACT_READ, 6'd48, 1'b0, '0, '0, '0));
    queue_cmd(make_cmd(ACT_WRITE, 6'd47, 1'b1, 19'h7ffff, 32'hffff_ffff, '0));
    queue_cmd(make_cmd(ACT_READ, 6'd47, 1'b0, '0, '0, '0));
    queue_cmd(make_cmd(ACT_WRITE, 6'd0, 1'b1, 19'h2aaaa, 32'hffff_ffff, '1));
    queue_cmd(make_cmd(ACT_LOOKUP, 6'd0, 1'b0, '0, '0, {18'h15555, 14'h3fff}));
    queue_cmd(make_cmd(ACT_LOOKUP, 6'd0, 1'b0, '0, '0, 32'hffff_ffff));
    queue_cmd(make_cmd(ACT_WRITE, 6'd13, 1'b0, 19'h55555, 32'h0, '0));
    queue_cmd(make_cmd(ACT_LOOKUP, 6'd63, 1'b1, '1, '1, 32'hffff_ffff));
    queue_cmd(make_cmd(ACT_WRITE, 6'd63, 1'b1, 19'h7ffff, 32'hffff_ffff, '1));
    queue_cmd(make_cmd(ACT_READ, 6'd63, 1'b1, '1, '1, '1));
    queue_cmd(make_cmd(ACT_WRITE, 6'd48, 1'b1, 19'h12345, 32'hdead_beef, '0));
    queue_cmd(make_cmd(ACT_NOOP, 6'd63, 1'b1, '1, '1, '1));
    queue_cmd(make_cmd(ACT_NOOP, 6'd0, 1'b0, '0, '0, '0));
    queue_cmd(make_cmd(ACT_WRITE, 6'd0, 1'b0, '0, '0, '1));
    queue_cmd(make_cmd(ACT_READ, 6'd0, 1'b0, '0, '0, '0));
    queue_cmd(make_cmd(ACT_READ, 6'd13, 1'b0, '0, '0, '0));
    wait_drained();

    // random phases; each starts after a full drain, which also pauses the sender
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      // refill every slot so lookups can miss and priority among real entries shows
      if (phase == 0 || phase == 2)
        for (int s = 0; s < NUM_ENTRIES; s++) queue_cmd(random_write(IDX_W'(s)));
      for (int n = 0; n < 420; n++) queue_cmd(random_item());
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (tlb_results_due.size() > 0) begin
      $error("%0d expected result beats never arrived", tlb_results_due.size());
      mismatch_count++;
    end
    $display("Run covered %0d writes, %0d reads, %0d lookups (%0d hits), %0d unused-action beats,",
             n_write, n_read, n_lookup, n_hit, n_noop);
    $display("%0d out-of-range slot accesses; %0d result beats checked under four pacing modes.",
             n_out_of_range, results_checked);
    if (mismatch_count == 0) begin
      $display("tlb_entry_match_search_unit verification clean");
    end else begin
      $display("tlb_entry_match_search_unit verification failed");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("tlb_entry_match_search_unit verification failed");
    $finish;
  end

endmodule
